>>> design/tcgw_pkg.sv
// shared constants, codes and types of the text console glyph writer
// no dependencies; imported by every module of the block
package tcgw_pkg;

  localparam int GLYPH_COUNT     = 128;
  localparam int MAX_SCREEN_DIM  = 4096;
  localparam int WORDS_PER_GLYPH = 4;
  localparam int STORE_WORDS     = GLYPH_COUNT * WORDS_PER_GLYPH;
  localparam int ADDR_W          = $clog2(STORE_WORDS);
  localparam int GLYPH_ROWS      = 16;
  localparam int ROW_CNT_W       = $clog2(GLYPH_ROWS);

  localparam int DIM_W    = 13;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int PIX_W    = 24;
  localparam int CODE_W   = 8;
  localparam int WIDX_W   = 9;
  localparam int WORD_W   = 32;
  localparam int MASK_W   = 8;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 32;

  localparam logic [DIM_W-1:0]  DIM_LIMIT      = DIM_W'(MAX_SCREEN_DIM);
  localparam logic [DIM_W-1:0]  WIDTH_RESET    = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET   = DIM_W'(768);
  localparam logic [CODE_W-1:0] NEWLINE_CODE   = CODE_W'(10);
  localparam int                DRAWABLE_LIMIT = 128;

  // input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // what the cursor tells the row engine about the character just taken
  typedef struct packed {
    logic [PIX_W-1:0] pix_base;
    logic             wrap_clear;
  } cursor_info_t;

endpackage

>>> design/tcgw_font_ram.sv
// font store: one write port, one registered read port, read-before-write
// depends on tcgw_pkg for depth and word width
module tcgw_font_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tcgw_pkg::ADDR_W-1:0] waddr,
  input  logic [tcgw_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [tcgw_pkg::ADDR_W-1:0] raddr,
  output logic [tcgw_pkg::WORD_W-1:0] rdata
);
  import tcgw_pkg::*;

  logic [WORD_W-1:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/tcgw_cursor.sv
// text cursor: column and row registers, advance and wrap, base pixel offset
// depends on tcgw_pkg for widths and cursor_info_t
module tcgw_cursor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [tcgw_pkg::CODE_W-1:0] code,
  input  logic [tcgw_pkg::DIM_W-1:0]  width_px,
  input  logic [tcgw_pkg::DIM_W-1:0]  height_px,
  output tcgw_pkg::cursor_info_t      info
);
  import tcgw_pkg::*;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [COL_W-1:0] cols;
  logic [ROW_W-1:0] rows;
  logic             wrap_line;
  logic [2*DIM_W-1:0] line_off;

  assign cols      = width_px[DIM_W-1:3];
  assign rows      = height_px[DIM_W-1:4];
  assign col_inc   = col + COL_W'(1);
  assign row_inc   = row + ROW_W'(1);
  assign wrap_line = (col_inc >= cols) || (code == NEWLINE_CODE);

  assign line_off        = {row, 4'b0000} * width_px;
  assign info.pix_base   = line_off[PIX_W-1:0] + PIX_W'({col, 3'b000});
  assign info.wrap_clear = wrap_line && (row_inc >= rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (wrap_line) begin
        col <= '0;
        row <= info.wrap_clear ? '0 : row_inc;
      end else begin
        col <= col_inc;
      end
    end
  end

endmodule

>>> design/text_console_glyph_writer_unit.sv
// text console glyph writer: 8x16 font store and row-write generator
// timing: a load, or an undrawn character that does not clear the screen, leaves
//   no job behind; a drawable character issues 16 row writes, one per cycle while
//   the output is not stalled, plus one clear-screen result when the cursor wraps
//   past the last text row; the next item is taken in the cycle that issues the
//   final result, so characters run back to back
// reset (rst, synchronous): cursor home, width 1024, height 768, no job;
//   the font store is not cleared and holds garbage until loaded
module text_console_glyph_writer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tcgw_pkg::DIM_W-1:0]    cfg_data,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] char_code, [16:8] font_word_index, [48:17] font_word, [55:49] zero
  input  logic [tcgw_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [23:0] pixel_index, [31:24] row_mask
  output logic [tcgw_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [0] clear_screen
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import tcgw_pkg::*;

  // configuration, stored already clamped to the largest screen
  logic [DIM_W-1:0] width_px;
  logic [DIM_W-1:0] height_px;
  logic [DIM_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data > DIM_LIMIT) ? DIM_LIMIT : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_px  <= WIDTH_RESET;
      height_px <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_px  <= cfg_clamped;
        REG_HEIGHT: height_px <= cfg_clamped;
        default:    ;
      endcase
    end
  end

  // input field unpacking
  logic              in_kind;
  logic [CODE_W-1:0] in_code;
  logic [WIDX_W-1:0] in_widx;
  logic [WORD_W-1:0] in_word;

  assign in_kind = s_axis_tuser;
  assign in_code = s_axis_tdata[CODE_W-1:0];
  assign in_widx = s_axis_tdata[CODE_W+WIDX_W-1:CODE_W];
  assign in_word = s_axis_tdata[CODE_W+WIDX_W+WORD_W-1:CODE_W+WIDX_W];

  logic in_xfer;
  logic char_xfer;
  logic load_xfer;
  logic in_draw;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign char_xfer = in_xfer && (in_kind == KIND_CHAR);
  assign load_xfer = in_xfer && (in_kind == KIND_LOAD)
                     && (32'(in_widx) < STORE_WORDS);
  // codes at or above the drawable limit draw no glyph: they move the cursor and may clear the screen
  assign in_draw   = (32'(in_code) < DRAWABLE_LIMIT) && (32'(in_code) < GLYPH_COUNT);

  // cursor: advances as the character transfer is taken
  cursor_info_t cur_info;

  tcgw_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .step      (char_xfer),
    .code      (in_code),
    .width_px  (width_px),
    .height_px (height_px),
    .info      (cur_info)
  );

  // job registers: one character in flight, one result slot issued per cycle while the output is not stalled
  logic                 busy;
  logic                 job_draw;   // glyph rows still to issue
  logic                 job_clear;  // clear-screen result still to issue
  logic [CODE_W-1:0]    job_code;
  logic [ROW_CNT_W-1:0] job_row;
  logic [PIX_W-1:0]     job_pix;

  logic                 issue;
  logic                 last_slot;
  logic [ADDR_W-1:0]    rd_addr;

  // output register, also the stage that meets the font memory read data
  logic                 out_valid;
  logic [PIX_W-1:0]     out_pix;
  logic [1:0]           out_sel;
  logic                 out_clear;
  logic                 out_last;
  logic [WORD_W-1:0]    rd_word;
  logic [MASK_W-1:0]    out_mask;

  // while a job is busy, a slot issues whenever the output register is free or being emptied
  assign issue     = busy && (!out_valid || m_axis_tready);
  assign last_slot = job_draw ? ((job_row == ROW_CNT_W'(GLYPH_ROWS - 1)) && !job_clear)
                              : 1'b1;
  // take the next item once the current one has no read left after this cycle;
  // a load taken then writes after the final read, since the memory reads first
  assign s_axis_tready = !busy || (issue && last_slot);

  assign rd_addr = ADDR_W'({job_code, job_row[ROW_CNT_W-1:2]});

  tcgw_font_ram u_font_ram (
    .clk   (clk),
    .we    (load_xfer),
    .waddr (ADDR_W'(in_widx)),
    .wdata (in_word),
    .re    (issue && job_draw),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // a new character replaces the job that issues its final slot this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      job_draw  <= 1'b0;
      job_clear <= 1'b0;
    end else if (char_xfer) begin
      busy      <= in_draw || cur_info.wrap_clear;
      job_draw  <= in_draw;
      job_clear <= cur_info.wrap_clear;
      job_code  <= in_code;
      job_row   <= '0;
      job_pix   <= cur_info.pix_base;
    end else if (issue) begin
      if (job_draw) begin
        job_row <= job_row + ROW_CNT_W'(1);
        job_pix <= job_pix + PIX_W'(width_px);
        if (job_row == ROW_CNT_W'(GLYPH_ROWS - 1)) begin
          job_draw <= 1'b0;
          if (!job_clear) begin
            busy <= 1'b0;
          end
        end
      end else begin
        // clear-screen slot always ends the job
        job_clear <= 1'b0;
        busy      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_pix   <= job_draw ? job_pix : '0;
      out_sel   <= job_row[1:0];
      out_clear <= !job_draw;
      out_last  <= last_slot;
    end
  end

  // byte zero of a font word is the top row of its group of four
  always_comb begin
    case (out_sel)
      2'd0:    out_mask = rd_word[7:0];
      2'd1:    out_mask = rd_word[15:8];
      2'd2:    out_mask = rd_word[23:16];
      2'd3:    out_mask = rd_word[31:24];
      default: out_mask = '0;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(out_clear ? {MASK_W{1'b0}} : out_mask), out_pix};
  assign m_axis_tuser  = out_clear;
  assign m_axis_tlast  = out_last;

  // a stalled output must freeze the row engine
  a_stall_freezes_job: assert property (@(posedge clk) disable iff (rst)
    busy && out_valid && !m_axis_tready |=> $stable(job_row) && $stable(job_pix))
    else $error("row engine moved while the output was stalled");

  // a new item only lands when the current job is on its final slot
  a_accept_on_last: assert property (@(posedge clk) disable iff (rst)
    in_xfer && busy |-> issue && last_slot)
    else $error("item taken while the current job still had slots");

  // a glyph row other than the bottom one is always followed by another row
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    issue && job_draw && (job_row != ROW_CNT_W'(GLYPH_ROWS - 1)) |=> busy && job_draw)
    else $error("glyph row sequence cut short");

  // the clear-screen result is always the final one of its item
  a_clear_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_clear |-> out_last)
    else $error("clear-screen result not marked last");

  // nothing is in flight right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !busy && !out_valid)
    else $error("job or output live after reset");

endmodule
